// ===== rtl/xoshiro_pkg.sv =====
// shared types, constants and command/status structs of the xoshiro256** generator
`default_nettype none

package xoshiro_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned NUM_WORDS = 4;

  // splitmix64 seeding constants
  localparam logic [WORD_W-1:0] SM_INCREMENT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] SM_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] SM_MUL_B     = 64'h94D0_49BB_1331_11EB;

  // xoshiro256 update shift and rotate amounts are fixed at 17 and 45
  localparam int unsigned XS_SHIFT = 17;
  localparam int unsigned XS_ROT   = 45;

  // jump-ahead polynomial, one bit per update step
  localparam logic [NUM_WORDS-1:0][WORD_W-1:0] JUMP_CONST = {
    64'h39AB_DC45_29B1_661C,
    64'hA958_2618_E03F_C9AA,
    64'hD5A6_1266_F0C9_392C,
    64'h180E_C6D3_3CFD_0ABA
  };

  // partial products of one truncated 64x64 multiply
  localparam logic [1:0] MUL_PART_LO    = 2'd0;
  localparam logic [1:0] MUL_PART_CROSS = 2'd1;
  localparam logic [1:0] MUL_PART_LAST  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NEXT = 2'd0,
    KIND_SEED = 2'd1,
    KIND_JUMP = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCRAMBLE,
    ST_SEED_PRE,
    ST_SEED_MUL_A,
    ST_SEED_MID,
    ST_SEED_MUL_B,
    ST_SEED_WRITE,
    ST_JUMP,
    ST_JUMP_COMMIT
  } state_t;

  typedef struct packed {
    logic       capture_next;  // take w1*5 and advance the words
    logic       load_seed;     // latch seed, restart word index
    logic       mix_pre;       // z = s ^ (s >> 30)
    logic       mul_step;      // one partial product into the accumulator
    logic [1:0] mul_part;
    logic       mul_sel_b;     // second mix multiplier
    logic       mix_mid;       // z = acc ^ (acc >> 27)
    logic       seed_write;    // word[k] = acc ^ (acc >> 31), s += increment
    logic       jump_clear;
    logic       jump_step;
    logic       jump_commit;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic word_last;
    logic jump_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/xoshiro_dp.sv =====
// datapath: generator words, splitmix multiplier, jump accumulator, output register
`default_nettype none

module xoshiro_dp
  import xoshiro_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [WORD_W-1:0] seed,
  input  wire dp_cmd_t           cmd,
  output dp_status_t             status,
  output logic [WORD_W-1:0]      random_value
);

  logic [NUM_WORDS-1:0][WORD_W-1:0] words_r, words_nxt;
  logic [NUM_WORDS-1:0][WORD_W-1:0] words_adv;
  logic [NUM_WORDS-1:0][WORD_W-1:0] jacc_r;
  logic [7:0]                       jump_step_r;
  logic [1:0]                       word_idx_r;
  logic [WORD_W-1:0]                p5_r, s_r, z_r, acc_r, out_r;
  logic [WORD_W-1:0]                mul_const;
  logic [HALF_W-1:0]                mul_a, mul_b;
  logic [WORD_W-1:0]                mul_p;
  logic [WORD_W-1:0]                rot_p5;
  logic                             jump_bit;

  function automatic logic [NUM_WORDS-1:0][WORD_W-1:0] advance(
    input logic [NUM_WORDS-1:0][WORD_W-1:0] w
  );
    logic [WORD_W-1:0] t, w0, w1, w2, w3;
    t  = w[1] << XS_SHIFT;
    w2 = w[2] ^ w[0];
    w3 = w[3] ^ w[1];
    w1 = w[1] ^ w2;
    w0 = w[0] ^ w3;
    w2 = w2 ^ t;
    w3 = {w3[WORD_W-XS_ROT-1:0], w3[WORD_W-1:WORD_W-XS_ROT]};
    return {w3, w2, w1, w0};
  endfunction

  assign words_adv = advance(words_r);

  // shared 32x32 multiplier, low 64 bits of z * const built from three products
  assign mul_const = cmd.mul_sel_b ? SM_MUL_B : SM_MUL_A;
  always_comb begin
    case (cmd.mul_part)
      MUL_PART_LO: begin
        mul_a = z_r[HALF_W-1:0];
        mul_b = mul_const[HALF_W-1:0];
      end
      MUL_PART_CROSS: begin
        mul_a = z_r[HALF_W-1:0];
        mul_b = mul_const[WORD_W-1:HALF_W];
      end
      default: begin
        mul_a = z_r[WORD_W-1:HALF_W];
        mul_b = mul_const[HALF_W-1:0];
      end
    endcase
  end
  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  assign jump_bit = JUMP_CONST[jump_step_r[7:6]][jump_step_r[5:0]];

  always_comb begin
    words_nxt = words_r;
    if (cmd.capture_next || cmd.jump_step) begin
      words_nxt = words_adv;
    end else if (cmd.seed_write) begin
      words_nxt[word_idx_r] = acc_r ^ (acc_r >> 31);
    end else if (cmd.jump_commit) begin
      words_nxt = jacc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r     <= '0;
      jump_step_r <= '0;
      word_idx_r  <= '0;
    end else begin
      words_r <= words_nxt;
      if (cmd.jump_step) begin
        jump_step_r <= jump_step_r + 8'd1;
      end
      if (cmd.load_seed) begin
        word_idx_r <= '0;
      end else if (cmd.seed_write) begin
        word_idx_r <= word_idx_r + 2'd1;
      end
    end
  end

  assign rot_p5 = {p5_r[WORD_W-8:0], p5_r[WORD_W-1:WORD_W-7]};

  always_ff @(posedge clk) begin
    if (cmd.capture_next) begin
      p5_r <= words_r[1] + (words_r[1] << 2);
    end
    if (cmd.load_seed) begin
      s_r <= seed;
    end else if (cmd.seed_write) begin
      s_r <= s_r + SM_INCREMENT;
    end
    if (cmd.mix_pre) begin
      z_r <= s_r ^ (s_r >> 30);
    end else if (cmd.mix_mid) begin
      z_r <= acc_r ^ (acc_r >> 27);
    end
    if (cmd.mul_step) begin
      if (cmd.mul_part == MUL_PART_LO) begin
        acc_r <= mul_p;
      end else begin
        acc_r <= acc_r + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end
    if (cmd.jump_clear) begin
      jacc_r <= '0;
    end else if (cmd.jump_step && jump_bit) begin
      jacc_r <= jacc_r ^ words_r;
    end
    if (cmd.out_load) begin
      out_r <= rot_p5 + (rot_p5 << 3);
    end
  end

  assign status.word_last = (word_idx_r == 2'd3);
  assign status.jump_last = (jump_step_r == 8'hFF);
  assign random_value     = out_r;

endmodule

`default_nettype wire

// ===== rtl/xoshiro_ctrl.sv =====
// controller: item sequencing, multiply steps and output valid
`default_nettype none

module xoshiro_ctrl
  import xoshiro_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] part_r, part_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       mul_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign mul_last  = (part_r == MUL_PART_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_NEXT: state_nxt = ST_SCRAMBLE;
            KIND_SEED: state_nxt = ST_SEED_PRE;
            KIND_JUMP: state_nxt = ST_JUMP;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCRAMBLE:    if (slot_free) state_nxt = ST_IDLE;
      ST_SEED_PRE:    state_nxt = ST_SEED_MUL_A;
      ST_SEED_MUL_A:  if (mul_last) state_nxt = ST_SEED_MID;
      ST_SEED_MID:    state_nxt = ST_SEED_MUL_B;
      ST_SEED_MUL_B:  if (mul_last) state_nxt = ST_SEED_WRITE;
      ST_SEED_WRITE:  state_nxt = status.word_last ? ST_IDLE : ST_SEED_PRE;
      ST_JUMP:        if (status.jump_last) state_nxt = ST_JUMP_COMMIT;
      ST_JUMP_COMMIT: state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd           = '0;
    cmd.mul_part  = part_r;
    in_stall      = (state_r != ST_IDLE);
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_NEXT: cmd.capture_next = 1'b1;
            KIND_SEED: cmd.load_seed    = 1'b1;
            KIND_JUMP: cmd.jump_clear   = 1'b1;
            default:   cmd.load_seed    = 1'b0;
          endcase
        end
      end
      ST_SCRAMBLE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      ST_SEED_PRE:   cmd.mix_pre = 1'b1;
      ST_SEED_MUL_A: cmd.mul_step = 1'b1;
      ST_SEED_MID:   cmd.mix_mid = 1'b1;
      ST_SEED_MUL_B: begin
        cmd.mul_step  = 1'b1;
        cmd.mul_sel_b = 1'b1;
      end
      ST_SEED_WRITE:  cmd.seed_write  = 1'b1;
      ST_JUMP:        cmd.jump_step   = 1'b1;
      ST_JUMP_COMMIT: cmd.jump_commit = 1'b1;
      default:        cmd.mul_step    = 1'b0;
    endcase
  end

  assign part_nxt = (cmd.mul_step && !mul_last) ? part_r + 2'd1 : MUL_PART_LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      part_r      <= MUL_PART_LO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/xoshiro256ss_generator_core.sv =====
// top level of the xoshiro256** generator: controller plus datapath
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_kind[1:0], in_seed[63:0]
//  out_    | output    | out_valid / out_stall | out_random_value[63:0]
//
// next transaction: accept, then scramble into the output register;
//   the scramble cycle waits while a previous result is still stalled at out_
// seed transaction: sequenced around the single shared 32x32 multiplier
//   (4 words x (pre-mix, 3 partial products, mid-mix, 3 partial products, write))
// jump transaction: one xoshiro update step per cycle over 256 bits
// reset clears the generator words, so the block must be seeded before use;
//   no clearing pass is needed and in_stall drops right after reset
`default_nettype none

module xoshiro256ss_generator_core
  import xoshiro_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_seed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_random_value
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing of every transaction kind, and the output valid flag
  xoshiro_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // state words, seeding arithmetic, jump accumulator and result register
  xoshiro_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .seed         (in_seed),
    .cmd          (cmd),
    .status       (status),
    .random_value (out_random_value)
  );

endmodule

`default_nettype wire

// ===== rtl/xoshiro_chk.sv =====
// port-level checker for the xoshiro256** generator and its bind
`default_nettype none

module xoshiro_chk
  import xoshiro_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_random_value
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_value))
    else $error("result changed while stalled");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // next, seed and jump all keep the input stalled after they are taken
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == KIND_NEXT || in_kind == KIND_SEED || in_kind == KIND_JUMP)
    |=> in_stall)
    else $error("input taken again too early");

  // a new result appears only from the busy scramble cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a busy cycle");

  // a seed transaction gives no result in the cycle after it is taken
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_SEED && !out_valid |=> !out_valid)
    else $error("seed produced a result");

endmodule

bind xoshiro256ss_generator_core xoshiro_chk u_chk (.*);

`default_nettype wire

// ===== dv/tb_xoshiro256ss_generator_core.sv =====
`timescale 1ns / 100ps
// testbench of the xoshiro256** generator core: directed table, then random transactions
module tb_xoshiro256ss_generator_core;
  import xoshiro_pkg::*;

  // kind code that the block drops without a result
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // splitmix64 seeding and xoshiro256 update, kept apart from the design's package
  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned SHIFT_AMT   = 17;
  localparam int unsigned ROT_AMT     = 45;
  localparam logic [3:0][63:0] JUMP_POLY = {
    64'h39AB_DC45_29B1_661C,
    64'hA958_2618_E03F_C9AA,
    64'hD5A6_1266_F0C9_392C,
    64'h180E_C6D3_3CFD_0ABA
  };

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 900;
  // a jump holds the input for its whole update pass, on top of the longest gaps and stalls
  localparam int IDLE_LIMIT    = 2000;
  // a trailing jump gives no result, so let it finish before closing
  localparam int TAIL_CYCLES   = 300;

  // one line of the directed table; known marks a result typed in by hand
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] seed;
    logic        known;
    logic [63:0] value;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = 2'd0;
  logic [63:0] in_seed = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_random_value;

  // generator words as the design should hold them after each accepted transaction
  logic [63:0] gen_words [4];
  // random values still owed by the design, oldest first
  logic [63:0] pending_randoms [$];
  int          errors = 0;
  int          idle_cycles = 0;
  // when set, neither side idles nor stalls
  bit          steady = 1'b0;

  xoshiro256ss_generator_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // splitmix64 finalizer
  function automatic logic [63:0] splitmix(input logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 30)) * MIX_MUL_A;
    t = (t ^ (t >> 27)) * MIX_MUL_B;
    return t ^ (t >> 31);
  endfunction

  // one xoshiro256 state update
  function automatic void advance_words();
    logic [63:0] t;
    t = gen_words[1] << SHIFT_AMT;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= t;
    gen_words[3] = rotl64(gen_words[3], ROT_AMT);
  endfunction

  // starstar scrambler on word 1, then update
  function automatic logic [63:0] next_output();
    logic [63:0] v;
    v = rotl64(gen_words[1] * 64'd5, 7) * 64'd9;
    advance_words();
    return v;
  endfunction

  // mix is taken before the increment, so word 0 is the mix of the seed itself
  function automatic void seed_words(input logic [63:0] s);
    int k;
    for (k = 0; k < 4; k++) begin
      gen_words[k] = splitmix(s);
      s += GOLDEN_STEP;
    end
  endfunction

  // 2^128 steps ahead: xor together the states picked by the jump polynomial
  function automatic void jump_words();
    logic [63:0] acc [4];
    int step;
    int k;
    for (k = 0; k < 4; k++) acc[k] = '0;
    for (step = 0; step < 256; step++) begin
      if (JUMP_POLY[step / 64][step % 64]) begin
        for (k = 0; k < 4; k++) acc[k] ^= gen_words[k];
      end
      advance_words();
    end
    for (k = 0; k < 4; k++) gen_words[k] = acc[k];
  endfunction

  // follow one accepted transaction; next transactions owe a random value
  function automatic void track_transaction(input row_t row);
    logic [63:0] v;
    case (row.kind)
      KIND_NEXT: begin
        v = next_output();
        pending_randoms.push_back(row.known ? row.value : v);
      end
      KIND_SEED: seed_words(row.seed);
      KIND_JUMP: jump_words();
      default: ;
    endcase
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
  endtask

  // drive one transaction, hold it while stalled, and return at the accepting edge
  task automatic send_item(input row_t row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= row.kind;
    in_seed  <= row.seed;
    forever begin
      @(posedge clk);
      if (in_stall == 1'b0) break;
    end
    track_transaction(row);
  endtask

  // stimulus: reset, directed table, then random transactions
  initial begin
    row_t        directed_rows [DIRECTED_ROWS];
    row_t        row;
    int          n;
    int          counted;
    int unsigned pick;
    for (n = 0; n < 4; n++) gen_words[n] = '0;
    directed_rows = '{
      // unseeded: next gives zero, jump and the unused kind leave the words at zero
      {KIND_NEXT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
      {KIND_JUMP,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b1, 64'h0},
      {KIND_UNUSED, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 64'h0},
      {KIND_NEXT,   64'h1234_5678_9ABC_DEF0, 1'b1, 64'h0},
      // seed extremes, seed field ignored on the other kinds
      {KIND_SEED,   64'h0,                   1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_NEXT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      {KIND_SEED,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_JUMP,   64'h0,                   1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_SEED,   64'h8000_0000_0000_0001, 1'b0, 64'h0},
      {KIND_NEXT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      {KIND_SEED,   64'h5555_5555_5555_5555, 1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      // back-to-back jumps
      {KIND_JUMP,   64'h0,                   1'b0, 64'h0},
      {KIND_JUMP,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_SEED,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0},
      {KIND_NEXT,   64'h0,                   1'b0, 64'h0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) send_item(directed_rows[n]);

    // random part: mostly next values from a seeded state, seeds and jumps mixed in,
    // unused kinds as noise that does not count
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 79) == 0) steady = !steady;
      pick = $urandom_range(0, 99);
      row.seed  = {$urandom, $urandom};
      row.known = 1'b0;
      row.value = '0;
      if (pick < 6) row.kind = KIND_SEED;
      else if (pick < 9) row.kind = KIND_JUMP;
      else if (pick < 12) row.kind = KIND_UNUSED;
      else row.kind = KIND_NEXT;
      send_item(row);
      if (row.kind != KIND_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    // drain, bounded by the watchdog
    while (pending_randoms.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side back-pressure: runs of ready cycles broken by stalls of random length
  initial begin
    int unsigned run;
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // every accepted result must match the oldest pending value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_randoms.size() == 0) begin
        report_mismatch("result with nothing pending", out_random_value, '0);
      end else begin
        if (out_random_value !== pending_randoms[0]) begin
          report_mismatch("random_value", out_random_value, pending_randoms[0]);
        end
        void'(pending_randoms.pop_front());
      end
    end
  end

  // watchdog: too long without a transaction on either side means a hang
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== xoshiro256ss_generator_core.f =====
rtl/xoshiro_pkg.sv
rtl/xoshiro_dp.sv
rtl/xoshiro_ctrl.sv
rtl/xoshiro256ss_generator_core.sv
rtl/xoshiro_chk.sv
dv/tb_xoshiro256ss_generator_core.sv
